### rtl/sparse_cholesky_triangular_solve_top_macros.svh
// assertion helpers for the triangular solve block
`ifndef SPARSE_CHOLESKY_TRIANGULAR_SOLVE_TOP_MACROS_SVH
`define SPARSE_CHOLESKY_TRIANGULAR_SOLVE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SCTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scts assertion failed");
// next-cycle implication
`define SCTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scts assertion failed");
`else
`define SCTS_ASSERT_IMP(lbl, ante, cons)
`define SCTS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/scts_pkg.sv
package scts_pkg;

  localparam int VAL_W            = 32;
  localparam int FRAC_W           = 16;
  localparam int FUNC_W           = 3;
  localparam int SLOT_W           = 14;
  localparam int LINK_W           = 15;
  localparam int ORDER_W          = 11;
  localparam int DEF_MAX_ORDER    = 1024;
  localparam int DEF_MAX_NONZEROS = 16384;

  localparam logic [FUNC_W-1:0] FN_COLST  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FACTOR = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FPERM  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_IPERM  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RHS    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SOLVE  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd6;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VMAX_V = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VMIN_V = {1'b1, {(VAL_W-1){1'b0}}};

  // result of a multi-cycle arithmetic unit
  typedef struct packed {
    logic done;
    logic ovf;
    val_t q;
  } arith_res_t;

  typedef struct packed {
    logic ovf;
    val_t v;
  } sat_t;

  // saturating a - b
  function automatic sat_t fx_sub(val_t a, val_t b);
    logic [VAL_W:0] d;
    sat_t r;
    d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    r.ovf = d[VAL_W] ^ d[VAL_W-1];
    if (r.ovf) begin
      r.v = d[VAL_W] ? VMIN_V : VMAX_V;
    end else begin
      r.v = d[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/scts_mul.sv
module scts_mul import scts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  val_t       a,
  input  val_t       b,
  output arith_res_t res
);

  localparam int PW = 2 * VAL_W;
  localparam logic signed [PW-1:0] RND = PW'((64'd1 << FRAC_W) - 64'd1);

  logic signed [PW-1:0] prod;
  logic                 prod_vld;
  logic signed [PW-1:0] adj;
  logic signed [PW-1:0] sh;
  logic                 ovf;

  // truncate toward zero, then saturate
  always_comb begin
    adj = prod[PW-1] ? prod + RND : prod;
    sh  = adj >>> FRAC_W;
    ovf = !((&sh[PW-1:VAL_W-1]) || (~|sh[PW-1:VAL_W-1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      res.done <= 1'b0;
    end else begin
      prod_vld <= start;
      res.done <= prod_vld;
    end
    prod    <= a * b;
    res.ovf <= ovf;
    res.q   <= ovf ? (sh[PW-1] ? VMIN_V : VMAX_V) : sh[VAL_W-1:0];
  end

endmodule

### rtl/scts_div.sv
module scts_div import scts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  val_t       a,
  input  val_t       b,
  output arith_res_t res
);

  localparam int DVD_W = VAL_W + FRAC_W;
  localparam int CW    = $clog2(DVD_W + 1);
  localparam logic [DVD_W-1:0] LIM_POS = DVD_W'(VMAX_V);
  localparam logic [DVD_W-1:0] LIM_NEG = LIM_POS + DVD_W'(1);

  logic             busy;
  logic             fin;
  logic [CW-1:0]    cnt;
  logic [DVD_W-1:0] dvd;
  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] ud;
  logic             neg;
  logic [VAL_W:0]   rem_s;
  logic [VAL_W:0]   rem_d;
  logic             ge;
  logic [VAL_W-1:0] ua;
  logic [VAL_W-1:0] ub;
  logic             q_ovf;
  logic [VAL_W-1:0] q_lo;

  always_comb begin
    ua    = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
    ub    = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
    rem_s = {rem, dvd[DVD_W-1]};
    rem_d = rem_s - {1'b0, ud};
    ge    = rem_s >= {1'b0, ud};
    q_ovf = dvd > (neg ? LIM_NEG : LIM_POS);
    q_lo  = dvd[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      fin      <= 1'b0;
      if (start && b == '0) begin
        res.done <= 1'b1;
      end else if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end else if (fin) begin
        res.done <= 1'b1;
      end
    end
    if (start) begin
      cnt <= CW'(DVD_W);
      dvd <= {ua, {FRAC_W{1'b0}}};
      rem <= '0;
      ud  <= ub;
      neg <= a[VAL_W-1] ^ b[VAL_W-1];
      // divide by zero saturates by the numerator sign
      res.ovf <= 1'b1;
      res.q   <= a[VAL_W-1] ? VMIN_V : ((a == '0) ? '0 : VMAX_V);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      rem <= ge ? rem_d[VAL_W-1:0] : rem_s[VAL_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
    end else if (fin) begin
      res.ovf <= q_ovf;
      if (q_ovf) begin
        res.q <= neg ? VMIN_V : VMAX_V;
      end else begin
        res.q <= neg ? -q_lo : q_lo;
      end
    end
  end

endmodule

### rtl/sparse_cholesky_triangular_solve_top.sv
// Sparse Cholesky triangular solver in signed Q16.16. Load beats (column start, factor entry
// with row index, permutation, inverse permutation, rhs element) are taken one per cycle while
// the block is idle and produce no result. A read beat returns its solution element through
// the read and emit states. A solve beat gathers the rhs through the permutation, runs forward
// substitution with L and backward substitution with L transposed, then scatters through the
// inverse permutation; it returns one status beat carrying the sticky overflow flag. In each
// direction, a column with a valid diagonal entry runs the 48-step radix-2 divider on it, and
// each off-diagonal nonzero takes a work vector read, a registered multiply and, in the
// forward pass, a write back to the work vector.
// Every store is a synchronous memory with one read and one write port; entries never loaded
// read as garbage.
// Products truncate toward zero; overflow and division by zero saturate and set the flag,
// which only reset clears. The order register may be written only while the block is idle.
module sparse_cholesky_triangular_solve_top import scts_pkg::*; #(
  parameter int MAX_ORDER    = DEF_MAX_ORDER,
  parameter int MAX_NONZEROS = DEF_MAX_NONZEROS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                order_we,
  input  logic [ORDER_W-1:0]  order_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [LINK_W-1:0]   link,
  input  val_t                value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output val_t                result_value,
  output logic                overflow
);

`include "sparse_cholesky_triangular_solve_top_macros.svh"

  localparam int CS_AW = $clog2(MAX_ORDER + 1);
  localparam int ORD_AW = $clog2(MAX_ORDER);
  localparam int NZ_AW = $clog2(MAX_NONZEROS);
  localparam int NZP_W = $clog2(MAX_NONZEROS + 1);
  localparam int NZE_W = 1 + ORD_AW + VAL_W;
  localparam int PE_W = 1 + ORD_AW;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_RD   = 5'd1;
  localparam logic [4:0] ST_EMIT = 5'd2;
  localparam logic [4:0] ST_G0   = 5'd3;
  localparam logic [4:0] ST_G1   = 5'd4;
  localparam logic [4:0] ST_G2   = 5'd5;
  localparam logic [4:0] ST_F0   = 5'd6;
  localparam logic [4:0] ST_F1   = 5'd7;
  localparam logic [4:0] ST_F2   = 5'd8;
  localparam logic [4:0] ST_F3   = 5'd9;
  localparam logic [4:0] ST_F4   = 5'd10;
  localparam logic [4:0] ST_F5   = 5'd11;
  localparam logic [4:0] ST_F6   = 5'd12;
  localparam logic [4:0] ST_F7   = 5'd13;
  localparam logic [4:0] ST_F8   = 5'd14;
  localparam logic [4:0] ST_F9   = 5'd15;
  localparam logic [4:0] ST_F10  = 5'd16;
  localparam logic [4:0] ST_B0   = 5'd17;
  localparam logic [4:0] ST_B1   = 5'd18;
  localparam logic [4:0] ST_B2   = 5'd19;
  localparam logic [4:0] ST_B3   = 5'd20;
  localparam logic [4:0] ST_B4   = 5'd21;
  localparam logic [4:0] ST_B5   = 5'd22;
  localparam logic [4:0] ST_B6   = 5'd23;
  localparam logic [4:0] ST_B7   = 5'd24;
  localparam logic [4:0] ST_B8   = 5'd25;
  localparam logic [4:0] ST_B9   = 5'd26;
  localparam logic [4:0] ST_B10  = 5'd27;
  localparam logic [4:0] ST_S0   = 5'd28;
  localparam logic [4:0] ST_S1   = 5'd29;
  localparam logic [4:0] ST_S2   = 5'd30;

  // stores
  logic [LINK_W-1:0] colst_mem [MAX_ORDER+1];
  logic [NZE_W-1:0]  nz_mem    [MAX_NONZEROS];
  logic [PE_W-1:0]   fperm_mem [MAX_ORDER];
  logic [PE_W-1:0]   iperm_mem [MAX_ORDER];
  val_t              rhs_mem   [MAX_ORDER];
  val_t              work_mem  [MAX_ORDER];
  val_t              sol_mem   [MAX_ORDER];

  logic              colst_we;
  logic [CS_AW-1:0]  colst_wa, colst_ra;
  logic [LINK_W-1:0] colst_q;
  logic              nz_we;
  logic [NZ_AW-1:0]  nz_wa, nz_ra;
  logic [NZE_W-1:0]  nz_wd, nz_q;
  logic              fperm_we, iperm_we;
  logic [ORD_AW-1:0] perm_wa, fperm_ra, iperm_ra;
  logic [PE_W-1:0]   perm_wd, fperm_q, iperm_q;
  logic              rhs_we;
  logic [ORD_AW-1:0] rhs_ra;
  val_t              rhs_q;
  logic              work_we;
  logic [ORD_AW-1:0] work_wa, work_ra;
  val_t              work_wd, work_q;
  logic              sol_we;
  logic [ORD_AW-1:0] sol_ra;
  val_t              sol_q;

  // control and datapath registers
  logic [4:0]        state;
  logic [ORDER_W-1:0] order;
  logic [CS_AW-1:0]  n;
  logic [CS_AW-1:0]  i;
  logic [NZP_W-1:0]  pb, pe, k;
  logic [ORD_AW-1:0] dg, rr;
  val_t              dval, acc, wd, wold, rfv, res_val;
  logic              res_kind;
  logic              sel_ok;
  logic              ovf_flag;

  logic        acc_in;
  logic [31:0] slot_x, link_x;
  logic        fp_ok, ip_ok, nz_ok;
  logic [ORD_AW-1:0] nz_idx;
  val_t        nz_val;
  logic [NZP_W-1:0] ptr_sat;
  logic        div_start, mul_start;
  val_t        div_a, mul_b;
  arith_res_t  div_res, mul_res;
  sat_t        sub_r;
  logic        out_free;

  assign acc_in   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign slot_x   = 32'(slot);
  assign link_x   = 32'(link);
  assign out_free = !out_valid || out_ready;

  // decode of stored entries against the active order
  assign nz_idx  = nz_q[VAL_W +: ORD_AW];
  assign nz_val  = nz_q[VAL_W-1:0];
  assign nz_ok   = nz_q[NZE_W-1] && (32'(nz_idx) < 32'(n));
  assign fp_ok   = fperm_q[PE_W-1] && (32'(fperm_q[ORD_AW-1:0]) < 32'(n));
  assign ip_ok   = iperm_q[PE_W-1] && (32'(iperm_q[ORD_AW-1:0]) < 32'(n));
  // column pointers clamp at the nonzero capacity
  assign ptr_sat = (32'(colst_q) > MAX_NONZEROS) ? NZP_W'(MAX_NONZEROS) : NZP_W'(colst_q);

  assign div_start = (state == ST_F5) || (state == ST_B6 && k >= pe);
  assign div_a     = (state == ST_F5) ? work_q : acc;
  assign mul_start = (state == ST_F9) || (state == ST_B8);
  // backward pass keeps the diagonal row's work value in acc until the column ends
  assign mul_b     = (state == ST_F9) ? wd : ((rr == dg) ? acc : work_q);
  assign sub_r     = fx_sub((state == ST_F10) ? wold : acc, mul_res.q);

  scts_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (div_a),
    .b     (dval),
    .res   (div_res)
  );

  scts_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (rfv),
    .b     (mul_b),
    .res   (mul_res)
  );

  // memory addressing
  always_comb begin
    colst_we = acc_in && func == FN_COLST && slot_x <= MAX_ORDER;
    colst_wa = slot_x[CS_AW-1:0];
    nz_we    = acc_in && func == FN_FACTOR && slot_x < MAX_NONZEROS;
    nz_wa    = slot_x[NZ_AW-1:0];
    nz_wd    = {link_x < MAX_ORDER, link_x[ORD_AW-1:0], value};
    fperm_we = acc_in && func == FN_FPERM && slot_x < MAX_ORDER;
    iperm_we = acc_in && func == FN_IPERM && slot_x < MAX_ORDER;
    rhs_we   = acc_in && func == FN_RHS && slot_x < MAX_ORDER;
    perm_wa  = slot_x[ORD_AW-1:0];
    perm_wd  = {link_x < MAX_ORDER, link_x[ORD_AW-1:0]};
    fperm_ra = i[ORD_AW-1:0];
    iperm_ra = i[ORD_AW-1:0];
    rhs_ra   = fperm_q[ORD_AW-1:0];
    sol_ra   = slot_x[ORD_AW-1:0];
    sol_we   = (state == ST_S2);
    work_ra  = (state == ST_S1) ? iperm_q[ORD_AW-1:0] : nz_idx;

    colst_ra = i;
    nz_ra    = k[NZ_AW-1:0];
    work_we  = 1'b0;
    work_wa  = dg;
    work_wd  = div_res.q;
    unique case (state) inside
      ST_F1: colst_ra = i + CS_AW'(1);
      ST_B0: colst_ra = i - CS_AW'(1);
      ST_F3, ST_B3: nz_ra = pb[NZ_AW-1:0];
      ST_G2: begin
        work_we = 1'b1;
        work_wa = i[ORD_AW-1:0];
        work_wd = sel_ok ? rhs_q : '0;
      end
      ST_F6, ST_B9: work_we = div_res.done;
      ST_F10: begin
        work_we = mul_res.done;
        work_wa = rr;
        work_wd = sub_r.v;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (colst_we) colst_mem[colst_wa] <= link;
    colst_q <= colst_mem[colst_ra];
    if (nz_we) nz_mem[nz_wa] <= nz_wd;
    nz_q <= nz_mem[nz_ra];
    if (fperm_we) fperm_mem[perm_wa] <= perm_wd;
    fperm_q <= fperm_mem[fperm_ra];
    if (iperm_we) iperm_mem[perm_wa] <= perm_wd;
    iperm_q <= iperm_mem[iperm_ra];
    if (rhs_we) rhs_mem[perm_wa] <= value;
    rhs_q <= rhs_mem[rhs_ra];
    if (work_we) work_mem[work_wa] <= work_wd;
    work_q <= work_mem[work_ra];
    if (sol_we) sol_mem[i[ORD_AW-1:0]] <= sel_ok ? work_q : '0;
    sol_q <= sol_mem[sol_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      order     <= ORDER_W'(1);
      ovf_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (order_we) order <= order_data;
      // the emit state sets valid itself
      if (out_valid && out_ready && state != ST_EMIT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (acc_in && func == FN_SOLVE) begin
            n     <= (32'(order) > MAX_ORDER) ? CS_AW'(MAX_ORDER) : CS_AW'(order);
            i     <= '0;
            state <= ST_G0;
          end else if (acc_in && func == FN_READ) begin
            res_kind <= 1'b1;
            res_val  <= '0;
            state    <= (slot_x < MAX_ORDER) ? ST_RD : ST_EMIT;
          end
        end
        ST_RD: begin
          res_val <= sol_q;
          state   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            kind         <= res_kind;
            result_value <= res_val;
            overflow     <= ovf_flag;
            state        <= ST_IDLE;
          end
        end
        // gather rhs through the permutation
        ST_G0: begin
          if (i == n) begin
            i     <= '0;
            state <= ST_F0;
          end else begin
            state <= ST_G1;
          end
        end
        ST_G1: begin
          sel_ok <= fp_ok;
          state  <= ST_G2;
        end
        ST_G2: begin
          i     <= i + CS_AW'(1);
          state <= ST_G0;
        end
        // forward substitution, column i
        ST_F0: state <= (i == n) ? ST_B0 : ST_F1;
        ST_F1: begin
          pb    <= ptr_sat;
          state <= ST_F2;
        end
        ST_F2: begin
          pe    <= ptr_sat;
          state <= ST_F3;
        end
        ST_F3: begin
          if (pb >= pe) begin
            i     <= i + CS_AW'(1);
            state <= ST_F0;
          end else begin
            state <= ST_F4;
          end
        end
        ST_F4: begin
          dg   <= nz_idx;
          dval <= nz_val;
          if (nz_ok) begin
            state <= ST_F5;
          end else begin
            i     <= i + CS_AW'(1);
            state <= ST_F0;
          end
        end
        ST_F5: state <= ST_F6;
        ST_F6: begin
          if (div_res.done) begin
            wd       <= div_res.q;
            ovf_flag <= ovf_flag | div_res.ovf;
            k        <= pb + NZP_W'(1);
            state    <= ST_F7;
          end
        end
        ST_F7: begin
          if (k >= pe) begin
            i     <= i + CS_AW'(1);
            state <= ST_F0;
          end else begin
            state <= ST_F8;
          end
        end
        ST_F8: begin
          rr  <= nz_idx;
          rfv <= nz_val;
          if (nz_ok) begin
            state <= ST_F9;
          end else begin
            k     <= k + NZP_W'(1);
            state <= ST_F7;
          end
        end
        ST_F9: begin
          wold  <= work_q;
          state <= ST_F10;
        end
        ST_F10: begin
          if (mul_res.done) begin
            // keep the multiplier operand current if the diagonal row is hit
            if (rr == dg) wd <= sub_r.v;
            ovf_flag <= ovf_flag | mul_res.ovf | sub_r.ovf;
            k        <= k + NZP_W'(1);
            state    <= ST_F7;
          end
        end
        // backward substitution, column i-1
        ST_B0: begin
          if (i == '0) begin
            state <= ST_S0;
          end else begin
            state <= ST_B1;
          end
        end
        ST_B1: begin
          pb    <= ptr_sat;
          state <= ST_B2;
        end
        ST_B2: begin
          pe    <= ptr_sat;
          state <= ST_B3;
        end
        ST_B3: begin
          if (pb >= pe) begin
            i     <= i - CS_AW'(1);
            state <= ST_B0;
          end else begin
            state <= ST_B4;
          end
        end
        ST_B4: begin
          dg   <= nz_idx;
          dval <= nz_val;
          if (nz_ok) begin
            state <= ST_B5;
          end else begin
            i     <= i - CS_AW'(1);
            state <= ST_B0;
          end
        end
        ST_B5: begin
          acc   <= work_q;
          k     <= pb + NZP_W'(1);
          state <= ST_B6;
        end
        ST_B6: state <= (k >= pe) ? ST_B9 : ST_B7;
        ST_B7: begin
          rr  <= nz_idx;
          rfv <= nz_val;
          if (nz_ok) begin
            state <= ST_B8;
          end else begin
            k     <= k + NZP_W'(1);
            state <= ST_B6;
          end
        end
        ST_B8: state <= ST_B10;
        ST_B10: begin
          if (mul_res.done) begin
            acc      <= sub_r.v;
            ovf_flag <= ovf_flag | mul_res.ovf | sub_r.ovf;
            k        <= k + NZP_W'(1);
            state    <= ST_B6;
          end
        end
        ST_B9: begin
          if (div_res.done) begin
            ovf_flag <= ovf_flag | div_res.ovf;
            i        <= i - CS_AW'(1);
            state    <= ST_B0;
          end
        end
        // scatter through the inverse permutation
        ST_S0: begin
          if (i == n) begin
            res_kind <= 1'b0;
            res_val  <= '0;
            state    <= ST_EMIT;
          end else begin
            state <= ST_S1;
          end
        end
        ST_S1: begin
          sel_ok <= ip_ok;
          state  <= ST_S2;
        end
        ST_S2: begin
          i     <= i + CS_AW'(1);
          state <= ST_S0;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a solve holds off further beats
  `SCTS_ASSERT_NEXT(a_solve_blocks, in_valid && in_ready && func == FN_SOLVE, !in_ready)
  // overflow is sticky until reset
  `SCTS_ASSERT_NEXT(a_flag_sticky, ovf_flag, ovf_flag)
  // a product only lands while the sequencer waits for it
  `SCTS_ASSERT_IMP(a_mul_owned, mul_res.done, state == ST_F10 || state == ST_B10)
  // a quotient only lands while the sequencer waits for it
  `SCTS_ASSERT_IMP(a_div_owned, div_res.done, state == ST_F6 || state == ST_B9)

endmodule
